@@ rtl/core/pidfd_pkg.sv @@
`timescale 1ns / 1ps
package pidfd_pkg;

  // Widths of the Q16.16 datapath
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int OP_W   = DATA_W + 1;          // multiplier operand, signed
  localparam int PROD_W = 2 * OP_W;            // full product
  localparam int SUM_W  = DATA_W + 2;          // room for a three-term sum
  localparam int LIM_W  = 31;                  // symmetric limit and inverse-period registers
  localparam int FRC_W  = 17;                  // smoothing and period registers
  localparam int IDX_W  = 3;

  localparam logic [FRC_W-1:0] ONE_Q = FRC_W'(65536);

  // Register map
  localparam logic [IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DERIV_SMOOTH = 3'd4;
  localparam logic [IDX_W-1:0] REG_DERIV_LIMIT = 3'd5;
  localparam logic [IDX_W-1:0] REG_SAMPLE_PER  = 3'd6;
  localparam logic [IDX_W-1:0] REG_INV_SAMPLE  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_FINAL
  } state_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_SP,
    MUL_DIFF_ISP,
    MUL_DS_RAWD,
    MUL_OMDS_PREVD,
    MUL_KP_ERR,
    MUL_KI_INT,
    MUL_KD_PREVD
  } mul_sel_t;

  typedef struct packed {
    logic     idle;
    logic     ld_err;
    logic     ld_diff;
    logic     ld_acc;
    logic     ld_int;
    logic     ld_rawd;
    logic     ld_f1;
    logic     ld_fsum;
    logic     ld_filt;
    logic     ld_p;
    logic     ld_i;
    logic     ld_sum;
    logic     finish;
    mul_sel_t mul_sel;
  } ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     hit;
  } clamp_t;

  // Saturate a sum that fits in SUM_W bits to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Symmetric clamp to +-lim; hit only when strictly beyond
  function automatic clamp_t clamp_sym(input logic signed [DATA_W-1:0] v,
                                       input logic [LIM_W-1:0] lim);
    clamp_t r;
    logic signed [DATA_W:0] vx;
    logic signed [DATA_W:0] lx;
    logic signed [DATA_W:0] nx;
    vx = {v[DATA_W-1], v};
    lx = $signed({2'b00, lim});
    nx = -lx;
    if (vx > lx) begin
      r.val = lx[DATA_W-1:0];
      r.hit = 1'b1;
    end else if (vx < nx) begin
      r.val = nx[DATA_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v;
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pidfd_if.sv @@
`timescale 1ns / 1ps
// Control tick channel
interface pidfd_tick_if;
  logic                             valid;
  logic                             ready;
  logic signed [pidfd_pkg::DATA_W-1:0] reference;
  logic signed [pidfd_pkg::DATA_W-1:0] feedback;
  logic                             clear;

  modport source (output valid, output reference, output feedback, output clear,
                  input ready);
  modport sink   (input valid, input reference, input feedback, input clear,
                  output ready);
endinterface

// Controller result channel
interface pidfd_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [pidfd_pkg::DATA_W-1:0] drive;
  logic                             saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

@@ rtl/core/pidfd_qmul.sv @@
`timescale 1ns / 1ps
// Shared Q16.16 multiplier: registered product, floor shift, saturation.
// The product is registered, so the result follows in the cycle after the operands are presented.
module pidfd_qmul (
  input  logic                                clk,
  input  logic signed [pidfd_pkg::OP_W-1:0]   a,
  input  logic signed [pidfd_pkg::OP_W-1:0]   b,
  output logic signed [pidfd_pkg::DATA_W-1:0] res
);
  import pidfd_pkg::*;

  localparam int SH_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [SH_W-1:0]   shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // arithmetic shift is floor division by 2^16
  assign shifted = prod[PROD_W-1:FRAC_W];

  always_comb begin
    if (shifted[SH_W-1:DATA_W-1] == '0 || shifted[SH_W-1:DATA_W-1] == '1) begin
      res = shifted[DATA_W-1:0];
    end else if (shifted[SH_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/core/pidfd_fsm.sv @@
`timescale 1ns / 1ps
// Sequencer: steps one tick through the shared multiplier
module pidfd_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             clr,
  input  logic             slot_free,
  output pidfd_pkg::ctrl_t ctrl
);
  import pidfd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ERR;
      ST_ERR:   state_next = clr ? ST_FINAL : ST_DIFF;
      ST_DIFF:  state_next = ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3:    state_next = ST_M4;
      ST_M4:    state_next = ST_M5;
      ST_M5:    state_next = ST_M6;
      ST_M6:    state_next = ST_M7;
      ST_M7:    state_next = ST_M8;
      ST_M8:    state_next = ST_FINAL;
      ST_FINAL: if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath strobes
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MUL_NONE;
    unique case (state)
      ST_IDLE:  ctrl.idle = 1'b1;
      ST_ERR:   ctrl.ld_err = 1'b1;
      ST_DIFF: begin
        ctrl.ld_diff = 1'b1;
        ctrl.mul_sel = MUL_ERR_SP;
      end
      ST_M1: begin
        ctrl.ld_acc  = 1'b1;
        ctrl.mul_sel = MUL_DIFF_ISP;
      end
      ST_M2: begin
        ctrl.ld_int  = 1'b1;
        ctrl.ld_rawd = 1'b1;
      end
      ST_M3:    ctrl.mul_sel = MUL_DS_RAWD;
      ST_M4: begin
        ctrl.ld_f1   = 1'b1;
        ctrl.mul_sel = MUL_OMDS_PREVD;
      end
      ST_M5: begin
        ctrl.ld_fsum = 1'b1;
        ctrl.mul_sel = MUL_KP_ERR;
      end
      ST_M6: begin
        ctrl.ld_filt = 1'b1;
        ctrl.ld_p    = 1'b1;
        ctrl.mul_sel = MUL_KI_INT;
      end
      ST_M7: begin
        ctrl.ld_i    = 1'b1;
        ctrl.mul_sel = MUL_KD_PREVD;
      end
      ST_M8:    ctrl.ld_sum = 1'b1;
      ST_FINAL: ctrl.finish = slot_free;
      default:  ctrl.idle = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/pid_controller_filtered_derivative.sv @@
`timescale 1ns / 1ps
// Channel   Dir   Beat payload
// tick      in    reference[31:0] s, feedback[31:0] s, clear
// result    out   drive[31:0] s, saturated
// write     in    write_en, write_index[2:0], write_data[31:0] (no read-back)
//
// A tick steps through ERR, DIFF, M1 to M8 and FINAL (a clear tick goes from ERR
// straight to FINAL); the result loads in FINAL, after seven passes through the
// one shared 33x33 multiplier plus the adds (none for a clear tick).
// One tick is in flight at a time; tick.ready is high only when idle.
// The result sits in an output register, so the next tick may be accepted
// while it waits; the final step stalls until that register is free.
// rst is synchronous: registers 0, state zeroed, integration disabled.
module pid_controller_filtered_derivative (
  input  logic                              clk,
  input  logic                              rst,
  pidfd_tick_if.sink                        tick,
  pidfd_result_if.source                    result,
  input  logic                              write_en,
  input  logic [pidfd_pkg::IDX_W-1:0]       write_index,
  input  logic [pidfd_pkg::DATA_W-1:0]      write_data
);
  import pidfd_pkg::*;

  // Configuration registers
  logic signed [DATA_W-1:0] gain_prop;
  logic signed [DATA_W-1:0] gain_integ;
  logic signed [DATA_W-1:0] gain_deriv;
  logic [LIM_W-1:0]         drive_limit;
  logic [FRC_W-1:0]         deriv_smoothing;
  logic [LIM_W-1:0]         deriv_limit;
  logic [FRC_W-1:0]         sample_period;
  logic [LIM_W-1:0]         inv_sample_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop         <= '0;
      gain_integ        <= '0;
      gain_deriv        <= '0;
      drive_limit       <= '0;
      deriv_smoothing   <= '0;
      deriv_limit       <= '0;
      sample_period     <= '0;
      inv_sample_period <= '0;
    end else if (write_en) begin
      unique case (write_index)
        REG_GAIN_PROP:    gain_prop         <= write_data;
        REG_GAIN_INTEG:   gain_integ        <= write_data;
        REG_GAIN_DERIV:   gain_deriv        <= write_data;
        REG_DRIVE_LIMIT:  drive_limit       <= write_data[LIM_W-1:0];
        REG_DERIV_SMOOTH: deriv_smoothing   <= write_data[FRC_W-1:0];
        REG_DERIV_LIMIT:  deriv_limit       <= write_data[LIM_W-1:0];
        REG_SAMPLE_PER:   sample_period     <= write_data[FRC_W-1:0];
        REG_INV_SAMPLE:   inv_sample_period <= write_data[LIM_W-1:0];
        default:          gain_prop         <= gain_prop;
      endcase
    end
  end

  ctrl_t ctrl;
  logic  start;
  logic  slot_free;
  logic  out_valid;

  // Latched tick
  logic signed [DATA_W-1:0] ref_r;
  logic signed [DATA_W-1:0] fb_r;
  logic                     clr_r;

  // Controller state
  logic signed [DATA_W-1:0] integral;
  logic signed [DATA_W-1:0] prev_error;
  logic signed [DATA_W-1:0] prev_deriv;
  logic                     int_en;

  // Intermediates
  logic signed [DATA_W-1:0] err;
  logic signed [DATA_W-1:0] diff;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] raw_d;
  logic signed [DATA_W-1:0] f1;
  logic signed [DATA_W-1:0] fsum;
  logic signed [DATA_W-1:0] p_term;
  logic signed [DATA_W-1:0] i_term;
  logic signed [DATA_W-1:0] sum;

  logic signed [DATA_W-1:0] drive_r;
  logic                     sat_r;

  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [DATA_W-1:0] mul_res;
  logic [FRC_W-1:0]         ds_eff;
  logic [FRC_W-1:0]         ds_inv;
  clamp_t                   int_clamp;
  clamp_t                   filt_clamp;
  clamp_t                   drive_clamp;

  // no beat is taken while reset is held
  assign tick.ready = ctrl.idle && !rst;
  assign start      = tick.valid && tick.ready;
  assign slot_free  = !out_valid || result.ready;

  pidfd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .clr       (clr_r),
    .slot_free (slot_free),
    .ctrl      (ctrl)
  );

  // Smoothing weight capped at one, and its complement
  assign ds_eff = (deriv_smoothing > ONE_Q) ? ONE_Q : deriv_smoothing;
  assign ds_inv = ONE_Q - ds_eff;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_ERR_SP: begin
        mul_a = {err[DATA_W-1], err};
        mul_b = $signed({{(OP_W-FRC_W){1'b0}}, sample_period});
      end
      MUL_DIFF_ISP: begin
        mul_a = {diff[DATA_W-1], diff};
        mul_b = $signed({{(OP_W-LIM_W){1'b0}}, inv_sample_period});
      end
      MUL_DS_RAWD: begin
        mul_a = $signed({{(OP_W-FRC_W){1'b0}}, ds_eff});
        mul_b = {raw_d[DATA_W-1], raw_d};
      end
      MUL_OMDS_PREVD: begin
        mul_a = $signed({{(OP_W-FRC_W){1'b0}}, ds_inv});
        mul_b = {prev_deriv[DATA_W-1], prev_deriv};
      end
      MUL_KP_ERR: begin
        mul_a = {gain_prop[DATA_W-1], gain_prop};
        mul_b = {err[DATA_W-1], err};
      end
      MUL_KI_INT: begin
        mul_a = {gain_integ[DATA_W-1], gain_integ};
        mul_b = {integral[DATA_W-1], integral};
      end
      MUL_KD_PREVD: begin
        mul_a = {gain_deriv[DATA_W-1], gain_deriv};
        mul_b = {prev_deriv[DATA_W-1], prev_deriv};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidfd_qmul u_qmul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  assign int_clamp   = clamp_sym(acc, drive_limit);
  assign filt_clamp  = clamp_sym(fsum, deriv_limit);
  assign drive_clamp = clamp_sym(sum, drive_limit);

  // Tick capture
  always_ff @(posedge clk) begin
    if (start) begin
      ref_r <= tick.reference;
      fb_r  <= tick.feedback;
      clr_r <= tick.clear;
    end
  end

  // Datapath intermediates
  always_ff @(posedge clk) begin
    if (ctrl.ld_err) begin
      err <= sat_sum(SUM_W'(ref_r) - SUM_W'(fb_r));
    end
    if (ctrl.ld_diff) begin
      diff <= sat_sum(SUM_W'(err) - SUM_W'(prev_error));
    end
    if (ctrl.ld_acc) begin
      acc <= sat_sum(SUM_W'(integral) + SUM_W'(mul_res));
    end
    if (ctrl.ld_rawd) begin
      raw_d <= mul_res;
    end
    if (ctrl.ld_f1) begin
      f1 <= mul_res;
    end
    if (ctrl.ld_fsum) begin
      fsum <= sat_sum(SUM_W'(f1) + SUM_W'(mul_res));
    end
    if (ctrl.ld_p) begin
      p_term <= mul_res;
    end
    if (ctrl.ld_i) begin
      i_term <= mul_res;
    end
    if (ctrl.ld_sum) begin
      sum <= sat_sum(SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(mul_res));
    end
  end

  // Controller state: integral, derivative memory, anti-windup enable
  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      prev_error <= '0;
      prev_deriv <= '0;
      int_en     <= 1'b0;
    end else if (ctrl.finish && clr_r) begin
      integral   <= '0;
      prev_error <= '0;
      prev_deriv <= '0;
      int_en     <= 1'b0;
    end else begin
      if (ctrl.ld_int && int_en) begin
        integral <= int_clamp.val;
      end
      if (ctrl.ld_filt) begin
        prev_deriv <= filt_clamp.val;
      end
      if (ctrl.finish) begin
        int_en     <= !drive_clamp.hit;
        prev_error <= err;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      drive_r <= clr_r ? '0 : drive_clamp.val;
      sat_r   <= clr_r ? 1'b0 : drive_clamp.hit;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = drive_r;
  assign result.saturated = sat_r;

  // The result register is only loaded when it is free
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> slot_free)
    else $error("result overwritten while still pending");

  // No second tick is taken while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("tick accepted while busy");

  // A clear tick leaves the controller in its reset state
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish && clr_r |=> integral == '0 && prev_deriv == '0 && !int_en)
    else $error("clear tick did not zero controller state");

  // Integration stays frozen while a saturated result is on display
  a_windup_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_r |-> !int_en)
    else $error("integration enabled after a saturated tick");

endmodule

@@ bench/pidfd_drive_check.sv @@
`timescale 1ns / 1ps
// Watches the tick, result and register write ports, runs its own model
// of the controller and compares every result beat against it.
module pidfd_drive_check (
  input  logic                         clk,
  input  logic                         rst,
  pidfd_tick_if                        tick,
  pidfd_result_if                      result,
  input  logic                         write_en,
  input  logic [pidfd_pkg::IDX_W-1:0]  write_index,
  input  logic [pidfd_pkg::DATA_W-1:0] write_data,
  output int                           failures,
  output int                           outstanding
);
  import pidfd_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
  } drive_beat_t;

  // Register copies
  logic signed [DATA_W-1:0] gain_p, gain_i, gain_d;
  logic [LIM_W-1:0]         out_lim, deriv_lim, inv_period;
  logic [FRC_W-1:0]         smoothing, period;

  // Controller state
  logic signed [DATA_W-1:0] integ_acc, last_err, last_deriv;
  logic                     integ_on;

  drive_beat_t drive_due[$];
  drive_beat_t want;
  int          fail_count = 0;

  assign failures = fail_count;

  function automatic logic signed [DATA_W-1:0] sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX[DATA_W-1:0];
    if (v < WORD_MIN) return WORD_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  // Q16.16 product, floor shift, saturated
  function automatic logic signed [DATA_W-1:0] q16_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_word(p >>> FRAC_W);
  endfunction

  // Symmetric clamp; hit only strictly beyond the limit
  function automatic logic signed [DATA_W-1:0] clamp_to(input logic signed [DATA_W-1:0] v,
                                                        input longint lim,
                                                        output logic hit);
    longint neg_lim;
    neg_lim = -lim;
    hit = 1'b0;
    if (longint'(v) > lim) begin
      hit = 1'b1;
      return lim[DATA_W-1:0];
    end
    if (longint'(v) < neg_lim) begin
      hit = 1'b1;
      return neg_lim[DATA_W-1:0];
    end
    return v;
  endfunction

  // One control tick: updates the state copy, returns the expected beat
  function automatic drive_beat_t controller_tick(input logic signed [DATA_W-1:0] sp,
                                                  input logic signed [DATA_W-1:0] meas,
                                                  input logic clr);
    drive_beat_t beat;
    longint smooth, lim, total;
    logic signed [DATA_W-1:0] err, diff, raw_d, filt;
    logic dummy, hit;
    beat = '0;
    if (clr) begin
      integ_acc  = '0;
      last_err   = '0;
      last_deriv = '0;
      integ_on   = 1'b0;
      return beat;
    end
    smooth = (smoothing > ONE_Q) ? longint'(ONE_Q) : longint'(smoothing);
    lim    = longint'(out_lim);
    err    = sat_word(longint'(sp) - longint'(meas));

    // integrator frozen after a saturated tick
    if (integ_on)
      integ_acc = clamp_to(sat_word(longint'(integ_acc) + longint'(q16_mul(err, period))),
                           lim, dummy);

    // filtered derivative
    diff  = sat_word(longint'(err) - longint'(last_err));
    raw_d = q16_mul(diff, inv_period);
    filt  = sat_word(longint'(q16_mul(smooth, raw_d)) +
                     longint'(q16_mul(longint'(ONE_Q) - smooth, last_deriv)));
    filt  = clamp_to(filt, longint'(deriv_lim), dummy);
    last_deriv = filt;

    total = longint'(q16_mul(gain_p, err)) + longint'(q16_mul(gain_i, integ_acc)) +
            longint'(q16_mul(gain_d, filt));
    beat.drive     = clamp_to(sat_word(total), lim, hit);
    beat.saturated = hit;
    integ_on = !hit;
    last_err = err;
    return beat;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_p     = '0;
      gain_i     = '0;
      gain_d     = '0;
      out_lim    = '0;
      deriv_lim  = '0;
      inv_period = '0;
      smoothing  = '0;
      period     = '0;
      integ_acc  = '0;
      last_err   = '0;
      last_deriv = '0;
      integ_on   = 1'b0;
      drive_due.delete();
    end else begin
      // compare a result beat against the oldest prediction
      if (result.valid && result.ready) begin
        if (drive_due.size() == 0) begin
          $error("result beat with no tick outstanding: drive %0d saturated %0b",
                 result.drive, result.saturated);
          fail_count++;
        end else begin
          want = drive_due.pop_front();
          if (result.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, result.drive);
            fail_count++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, result.saturated);
            fail_count++;
          end
        end
      end
      if (tick.valid && tick.ready)
        drive_due.push_back(controller_tick(tick.reference, tick.feedback, tick.clear));
      if (write_en) begin
        case (write_index)
          REG_GAIN_PROP:    gain_p     = write_data;
          REG_GAIN_INTEG:   gain_i     = write_data;
          REG_GAIN_DERIV:   gain_d     = write_data;
          REG_DRIVE_LIMIT:  out_lim    = write_data[LIM_W-1:0];
          REG_DERIV_SMOOTH: smoothing  = write_data[FRC_W-1:0];
          REG_DERIV_LIMIT:  deriv_lim  = write_data[LIM_W-1:0];
          REG_SAMPLE_PER:   period     = write_data[FRC_W-1:0];
          REG_INV_SAMPLE:   inv_period = write_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= drive_due.size();
  end

endmodule

@@ bench/pid_controller_filtered_derivative_test.sv @@
`timescale 1ns / 1ps
module pid_controller_filtered_derivative_test;
  import pidfd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_TICKS   = 128;

  localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sd65536;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              write_en = 1'b0;
  logic [IDX_W-1:0]  write_index = '0;
  logic [DATA_W-1:0] write_data = '0;

  int src_idle_pct = 7;
  int snk_idle_pct = 64;
  int failures;
  int outstanding;
  int idle_cycles = 0;

  // slow plant model used to build realistic tick sequences
  logic signed [DATA_W-1:0] setpoint = '0;
  logic signed [DATA_W-1:0] plant = '0;

  pidfd_tick_if   tick_ch();
  pidfd_result_if result_ch();

  pid_controller_filtered_derivative dut (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_ch),
    .result      (result_ch),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  pidfd_drive_check drive_check (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_ch),
    .result      (result_ch),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result receiver stalls at random
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[pid_controller_filtered_derivative] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] near_val(input int units);
    int span;
    span = units * 65536;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [DATA_W-1:0] wild_val();
    case ($urandom_range(4))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain(input int units);
    if ($urandom_range(7) == 0) return $urandom();
    return near_val(units);
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit(input int units);
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h7fffffff;
      2: return $urandom();
      default: return $urandom_range(Q_ONE / 4, units * Q_ONE);
    endcase
  endfunction

  // drop valid, drain all results, then let the block go quiet
  task automatic settle();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [DATA_W-1:0] kp, ki, kd, lim, smooth, dlim,
                              per, inv);
    logic [IDX_W-1:0]  idx [8];
    logic [DATA_W-1:0] vals [8];
    idx  = '{REG_GAIN_PROP, REG_GAIN_INTEG, REG_GAIN_DERIV, REG_DRIVE_LIMIT,
             REG_DERIV_SMOOTH, REG_DERIV_LIMIT, REG_SAMPLE_PER, REG_INV_SAMPLE};
    vals = '{kp, ki, kd, lim, smooth, dlim, per, inv};
    settle();
    for (int i = 0; i < 8; i++) begin
      write_en    <= 1'b1;
      write_index <= idx[i];
      write_data  <= vals[i];
      @(posedge clk);
    end
    write_en <= 1'b0;
  endtask

  task automatic program_random_regs();
    program_regs(pick_gain(2), pick_gain(2), pick_gain(1), pick_limit(40),
                 ($urandom_range(7) == 0) ? $urandom_range(65537, 131071)
                                          : $urandom_range(0, 65536),
                 pick_limit(40),
                 ($urandom_range(7) == 0) ? $urandom_range(0, 65536)
                                          : $urandom_range(65, 6554),
                 ($urandom_range(7) == 0) ? $urandom() : $urandom_range(Q_ONE, 1000 * Q_ONE));
  endtask

  // one tick beat; valid stays up after acceptance unless a gap follows
  task automatic send_tick(input logic signed [DATA_W-1:0] sp, meas, input logic clr);
    while ($urandom_range(99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.reference <= sp;
    tick_ch.feedback  <= meas;
    tick_ch.clear     <= clr;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // mostly a plant tracking a setpoint, some wild values, a few clears
  task automatic random_tick();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      send_tick(wild_val(), wild_val(), 1'b1);
    end else if (roll < 15) begin
      send_tick(wild_val(), wild_val(), 1'b0);
    end else begin
      if ($urandom_range(19) == 0) setpoint = near_val(20);
      plant = plant + ((setpoint - plant) >>> 3) + near_val(1) / 4;
      send_tick(setpoint, plant, 1'b0);
    end
  endtask

  initial begin
    tick_ch.valid     <= 1'b0;
    tick_ch.reference <= '0;
    tick_ch.feedback  <= '0;
    tick_ch.clear     <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // typical gains; first tick after reset and after clear skip integration
    program_regs(Q_ONE, Q_ONE / 2, Q_ONE / 4, 10 * Q_ONE, Q_ONE / 2, 5 * Q_ONE, 655,
                 100 * Q_ONE);
    send_tick(Q_ONE, 0, 1'b0);
    send_tick(Q_ONE, Q_ONE / 2, 1'b0);
    send_tick(2 * Q_ONE, Q_ONE / 4, 1'b0);
    send_tick(WORD_MAX, WORD_MIN, 1'b0);
    send_tick(WORD_MIN, WORD_MAX, 1'b0);
    send_tick(0, 0, 1'b0);
    send_tick(-1, 0, 1'b0);
    send_tick(WORD_MAX, WORD_MIN, 1'b1);
    send_tick(3 * Q_ONE, Q_ONE, 1'b0);
    send_tick(3 * Q_ONE, Q_ONE, 1'b0);

    // proportional only: output exactly at and just past the limit,
    // smoothing written above one
    program_regs(Q_ONE, 0, 0, 10 * Q_ONE, 32'h1ffff, 32'h7fffffff, 65536, 32'h7fffffff);
    send_tick(10 * Q_ONE, 0, 1'b0);
    send_tick(0, 10 * Q_ONE, 1'b0);
    send_tick(10 * Q_ONE + 1, 0, 1'b0);
    send_tick(0, 10 * Q_ONE + 1, 1'b0);
    send_tick(5 * Q_ONE, 0, 1'b0);

    // extremes: zero limits and periods, extreme gains
    program_regs(WORD_MIN, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 0);
    send_tick(1, 0, 1'b0);
    send_tick(0, 0, 1'b0);
    send_tick(WORD_MIN, 0, 1'b0);

    program_regs(WORD_MAX, WORD_MIN, WORD_MIN, 32'h7fffffff, 65536, 32'h7fffffff, 65536,
                 32'h7fffffff);
    send_tick(WORD_MAX, WORD_MIN, 1'b0);
    send_tick(WORD_MIN, WORD_MAX, 1'b0);
    send_tick(Q_ONE, -Q_ONE, 1'b0);
    send_tick(0, 0, 1'b1);

    // random phases under each idling mode
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 64 : 0;
      snk_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 7 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        program_random_regs();
        repeat (PHASE_TICKS) random_tick();
      end
    end

    settle();
    if (failures == 0) begin
      $display("[pid_controller_filtered_derivative] OK");
    end else begin
      $display("[pid_controller_filtered_derivative] ERROR");
    end
    $finish;
  end

endmodule
